FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL files.
// All checks sample on the rising edge of clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mcfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfr_pkg
// Shared types and constants of the motor command frame receiver.
// ----------------------------------------------------------------------------
package mcfr_pkg;

    // Header bytes 'M', 'O', 'T' ('O' also closes the header)
    localparam logic [7:0] HDR_M = 8'd77;
    localparam logic [7:0] HDR_O = 8'd79;
    localparam logic [7:0] HDR_T = 8'd84;

    // Command tag in payload bytes 3..6
    localparam logic [7:0] TAG_S = 8'h53;
    localparam logic [7:0] TAG_T = 8'h54;
    localparam logic [7:0] TAG_P = 8'h50;
    localparam logic [7:0] TAG_R = 8'h52;

    // Reflected CRC-8 polynomial
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Speed after reset
    localparam logic [7:0] SPEED_RESET = 8'd150;

    // Payload bytes that carry command fields and tag
    localparam int CMD_BYTES = 7;
    localparam int CMD_IDX_W = 3;

    // Header matcher progress
    localparam logic [1:0] HM_IDLE = 2'd0;
    localparam logic [1:0] HM_M    = 2'd1;
    localparam logic [1:0] HM_MO   = 2'd2;
    localparam logic [1:0] HM_MOT  = 2'd3;

    typedef enum logic [1:0] {
        STATUS_NONE   = 2'd0,
        STATUS_ACCEPT = 2'd1,
        STATUS_REJECT = 2'd2
    } frame_status_t;

    typedef struct packed {
        logic [7:0]    motor_speed;
        logic          motor_reverse;
        logic          motor_enable;
        logic          header_detected;
        frame_status_t frame_status;
    } result_t;

endpackage

FILE: rtl/core/motor_command_frame_receiver.sv
`timescale 1ns / 1ps
// Path: a byte is held in the input register, processed once the result
// register is empty or taken and shown from it (two register stages).
// Throughput: one byte per cycle; set by the input and result registers,
// which advance together whenever the result register is empty or taken.
// Reset: rst_n clears all control state, the header matcher and the frame
// position; the latched speed returns to 150, enable and direction to 0.
// ----------------------------------------------------------------------------
// motor_command_frame_receiver
// Parses 'MOTO' framed, CRC-8 checked motor commands from a byte stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module motor_command_frame_receiver #(
    parameter int PAYLOAD_BYTES = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] frame_status, [2] header_detected,
                                   // [3] motor_enable, [4] motor_reverse,
                                   // [12:5] motor_speed, [15:13] zero
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    mcfr_pkg::result_t out_reg;
    mcfr_pkg::result_t result;
    logic              out_free;
    logic              step;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    mcfr_parser #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .rx_byte(in_byte_reg),
        .result (result)
    );

    // Input register: take a word whenever the stage drains or is empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
    end

    // Result register: load on each processed byte, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.motor_speed, out_reg.motor_reverse,
                       out_reg.motor_enable, out_reg.header_detected,
                       2'(out_reg.frame_status)};

    // Checks
    `ASSERT_IMPL(a_stall_only_on_full, !s_tready, m_tvalid && !m_tready,
                 "input stalled while result side can advance")
    `ASSERT_IMPL(a_header_no_status, m_tvalid && m_tdata[2],
                 m_tdata[1:0] == 2'(mcfr_pkg::STATUS_NONE),
                 "header byte reported a frame end")
    `ASSERT_NEXT(a_drain_empties, m_tvalid && m_tready && !in_valid_reg, !m_tvalid,
                 "result repeated after being taken")

endmodule

FILE: rtl/core/mcfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfr_parser
// Header matcher, payload buffer, CRC-8 and command latch for one byte.
// ----------------------------------------------------------------------------
module mcfr_parser #(
    parameter int PAYLOAD_BYTES = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    output mcfr_pkg::result_t result
);

    localparam int POS_W = $clog2(PAYLOAD_BYTES + 2);
    localparam logic [POS_W-1:0] POS_CHECK = POS_W'(PAYLOAD_BYTES);
    localparam logic [POS_W-1:0] POS_CMD   = POS_W'(mcfr_pkg::CMD_BYTES);

    logic [1:0]       hm_reg, hm_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic             enable_reg, enable_next;
    logic             reverse_reg, reverse_next;
    logic [7:0]       speed_reg, speed_next;
    logic [7:0]       buf_reg [mcfr_pkg::CMD_BYTES];

    // Reflected CRC-8 over one byte, LSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ mcfr_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    logic header_done;
    logic tag_ok;

    assign header_done = (hm_reg == mcfr_pkg::HM_MOT) && (rx_byte == mcfr_pkg::HDR_O);
    assign tag_ok = (buf_reg[3] == mcfr_pkg::TAG_S) && (buf_reg[4] == mcfr_pkg::TAG_T)
                 && (buf_reg[5] == mcfr_pkg::TAG_P) && (buf_reg[6] == mcfr_pkg::TAG_R);

    // Compute next state and the result word for this byte
    always_comb
    begin
        hm_next      = hm_reg;
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        enable_next  = enable_reg;
        reverse_next = reverse_reg;
        speed_next   = speed_reg;
        result.frame_status    = mcfr_pkg::STATUS_NONE;
        result.header_detected = 1'b0;

        if (header_done)
        begin
            hm_next  = mcfr_pkg::HM_IDLE;
            pos_next = '0;
            crc_next = '0;
            result.header_detected = 1'b1;
        end
        else
        begin
            priority if (hm_reg == mcfr_pkg::HM_MO && rx_byte == mcfr_pkg::HDR_T)
                hm_next = mcfr_pkg::HM_MOT;
            else if (hm_reg == mcfr_pkg::HM_M && rx_byte == mcfr_pkg::HDR_O)
                hm_next = mcfr_pkg::HM_MO;
            else if (rx_byte == mcfr_pkg::HDR_M)
                hm_next = mcfr_pkg::HM_M;
            else
                hm_next = mcfr_pkg::HM_IDLE;

            if (pos_reg < POS_CHECK)
            begin
                crc_next = crc8_step(crc_reg, rx_byte);
            end
            else if (pos_reg == POS_CHECK)
            begin
                if (crc_reg == rx_byte && tag_ok)
                begin
                    enable_next  = (buf_reg[0] != 8'd0);
                    reverse_next = (buf_reg[1] != 8'd0);
                    speed_next   = buf_reg[2];
                    result.frame_status = mcfr_pkg::STATUS_ACCEPT;
                end
                else
                begin
                    result.frame_status = mcfr_pkg::STATUS_REJECT;
                end
            end

            // Advance the position, saturating one past the check byte
            if (pos_reg <= POS_CHECK)
                pos_next = pos_reg + POS_W'(1);
        end

        result.motor_enable  = enable_next;
        result.motor_reverse = reverse_next;
        result.motor_speed   = speed_next;
    end

    // Hold frame state; update on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hm_reg      <= mcfr_pkg::HM_IDLE;
            pos_reg     <= '0;
            crc_reg     <= '0;
            enable_reg  <= 1'b0;
            reverse_reg <= 1'b0;
            speed_reg   <= mcfr_pkg::SPEED_RESET;
        end
        else if (step)
        begin
            hm_reg      <= hm_next;
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            enable_reg  <= enable_next;
            reverse_reg <= reverse_next;
            speed_reg   <= speed_next;
        end
    end

    // Buffer the command bytes; later payload bytes only feed the CRC
    always_ff @(posedge clk)
    begin
        if (step && !header_done && pos_reg < POS_CMD)
            buf_reg[pos_reg[mcfr_pkg::CMD_IDX_W-1:0]] <= rx_byte;
    end

endmodule
